/* hw/rtl/isfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_pkg: shared types and constants of the sensor frame parser
// Channel payloads, the entry carried from front to back, frame constants and
// result status codes.
// ----------------------------------------------------------------------------
package isfp_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [7:0] TYPE_ANGLE  = 8'h53;
   localparam logic [7:0] TYPE_QUAT   = 8'h59;
   localparam int         PAYLOAD_LEN = 8;
   localparam int         IDX_BITS    = 4;
   localparam int         OUT_CNT_BITS = 32;

   localparam logic [1:0] STATUS_ANGLE = 2'd0;
   localparam logic [1:0] STATUS_QUAT  = 2'd1;
   localparam logic [1:0] STATUS_OTHER = 2'd2;
   localparam logic [1:0] STATUS_BAD   = 2'd3;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]               frame_type;
      logic [1:0]               status;
      logic signed [15:0]       word0;
      logic signed [15:0]       word1;
      logic signed [15:0]       word2;
      logic signed [15:0]       word3;
      logic                     angle_seen;
      logic                     quat_seen;
      logic [OUT_CNT_BITS-1:0]  angle_frames;
      logic [OUT_CNT_BITS-1:0]  quat_frames;
      logic [OUT_CNT_BITS-1:0]  bad_sums;
      logic [OUT_CNT_BITS-1:0]  bytes_seen;
   } rsp_payload_type;

   // one queued job: either a finished frame or a flag clear
   typedef struct packed {
      logic                     is_clear;
      logic [7:0]               frame_type;
      logic                     sum_ok;
      logic signed [15:0]       word0;
      logic signed [15:0]       word1;
      logic signed [15:0]       word2;
      logic signed [15:0]       word3;
      logic [OUT_CNT_BITS-1:0]  byte_count;
   } job_type;

endpackage

/* hw/rtl/isfp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_front: byte parser
// Hunts for the header, takes the type and payload bytes, keeps a running
// checksum and the byte counter, and issues one job per frame or resync.
// ----------------------------------------------------------------------------
module isfp_front #(
   parameter int COUNTER_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_fire,
   input  isfp_pkg::req_payload_type req_data,
   output logic                      push_valid,
   output isfp_pkg::job_type         push_data
);

   typedef enum logic [2:0] {
      PH_HEAD    = 3'b001,
      PH_TYPE    = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   localparam int SLOT_BITS = $clog2(isfp_pkg::PAYLOAD_LEN);

   phase_type                          phase_ff, phase_in;
   logic [7:0]                         type_ff, type_in;
   logic [7:0]                         sum_ff, sum_in;
   logic [isfp_pkg::IDX_BITS-1:0]      idx_ff, idx_in;
   logic [COUNTER_BITS-1:0]            bytes_ff, bytes_in;
   logic [COUNTER_BITS-1:0]            bytes_next;
   logic [7:0]                         pay_ff [isfp_pkg::PAYLOAD_LEN];
   logic                               pay_we;
   logic                               last_byte;

   // byte counter wraps at its own width
   assign bytes_next = bytes_ff + 1'b1;
   assign last_byte = (idx_ff == isfp_pkg::IDX_BITS'(isfp_pkg::PAYLOAD_LEN));
   assign pay_we    = req_fire && !req_data.cmd && (phase_ff == PH_PAYLOAD) && !last_byte;

   always_comb begin
      phase_in   = phase_ff;
      type_in    = type_ff;
      sum_in     = sum_ff;
      idx_in     = idx_ff;
      bytes_in   = bytes_ff;
      push_valid = 1'b0;

      push_data.is_clear   = req_data.cmd;
      push_data.frame_type = type_ff;
      push_data.sum_ok     = (sum_ff == req_data.rx_byte);
      push_data.word0      = {pay_ff[1], pay_ff[0]};
      push_data.word1      = {pay_ff[3], pay_ff[2]};
      push_data.word2      = {pay_ff[5], pay_ff[4]};
      push_data.word3      = {pay_ff[7], pay_ff[6]};
      push_data.byte_count = isfp_pkg::OUT_CNT_BITS'(bytes_next);

      if (req_fire) begin
         if (req_data.cmd) begin
            // resync: restart the hunt, back end clears the flags in order
            phase_in   = PH_HEAD;
            type_in    = 8'h00;
            idx_in     = '0;
            push_valid = 1'b1;
         end else begin
            bytes_in = bytes_next;
            unique case (phase_ff)
               PH_HEAD: begin
                  if (req_data.rx_byte == isfp_pkg::HEADER_BYTE) begin
                     phase_in = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  // repeated headers are skipped
                  if (req_data.rx_byte != isfp_pkg::HEADER_BYTE) begin
                     type_in  = req_data.rx_byte;
                     idx_in   = '0;
                     sum_in   = isfp_pkg::HEADER_BYTE + req_data.rx_byte;
                     phase_in = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  if (last_byte) begin
                     push_valid = 1'b1;
                     idx_in     = '0;
                     phase_in   = PH_HEAD;
                  end else begin
                     sum_in = sum_ff + req_data.rx_byte;
                     idx_in = idx_ff + 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_HEAD;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         idx_ff   <= '0;
         bytes_ff <= '0;
         type_ff  <= 8'h00;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         bytes_ff <= bytes_in;
         type_ff  <= type_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (pay_we) begin
         pay_ff[idx_ff[SLOT_BITS-1:0]] <= req_data.rx_byte;
      end
   end

endmodule

/* hw/rtl/isfp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_queue: short job queue
// Flop-based first-in first-out buffer between the parser and the result end.
// ----------------------------------------------------------------------------
module isfp_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  isfp_pkg::job_type push_data,
   output logic              full,
   output logic              pop_valid,
   input  logic              pop,
   output isfp_pkg::job_type pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   isfp_pkg::job_type   slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in;
   logic [PTR_BITS-1:0] rd_ff, rd_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/isfp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_back: frame classifier and result register
// Classifies each finished frame, keeps valid flags and frame counters, and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module isfp_back #(
   parameter int COUNTER_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   input  isfp_pkg::job_type         job_data,
   output logic                      job_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output isfp_pkg::rsp_payload_type rsp_data
);

   logic                      angle_flag_ff, angle_flag_in;
   logic                      quat_flag_ff, quat_flag_in;
   logic [COUNTER_BITS-1:0]   angle_cnt_ff, angle_cnt_in;
   logic [COUNTER_BITS-1:0]   quat_cnt_ff, quat_cnt_in;
   logic [COUNTER_BITS-1:0]   fail_cnt_ff, fail_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   isfp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [1:0]                status;

   // a clear never needs the output register
   assign job_pop = job_valid && (job_data.is_clear || !rsp_valid_ff || rsp_ready);

   always_comb begin
      angle_flag_in = angle_flag_ff;
      quat_flag_in  = quat_flag_ff;
      angle_cnt_in  = angle_cnt_ff;
      quat_cnt_in   = quat_cnt_ff;
      fail_cnt_in   = fail_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      status        = isfp_pkg::STATUS_OTHER;

      if (!job_data.sum_ok) begin
         status = isfp_pkg::STATUS_BAD;
      end else if (job_data.frame_type == isfp_pkg::TYPE_ANGLE) begin
         status = isfp_pkg::STATUS_ANGLE;
      end else if (job_data.frame_type == isfp_pkg::TYPE_QUAT) begin
         status = isfp_pkg::STATUS_QUAT;
      end

      if (job_pop) begin
         if (job_data.is_clear) begin
            angle_flag_in = 1'b0;
            quat_flag_in  = 1'b0;
         end else begin
            unique case (status)
               isfp_pkg::STATUS_BAD: begin
                  fail_cnt_in = fail_cnt_ff + 1'b1;
               end
               isfp_pkg::STATUS_ANGLE: begin
                  angle_flag_in = 1'b1;
                  angle_cnt_in  = angle_cnt_ff + 1'b1;
               end
               isfp_pkg::STATUS_QUAT: begin
                  quat_flag_in = 1'b1;
                  quat_cnt_in  = quat_cnt_ff + 1'b1;
               end
               default: begin
               end
            endcase
            rsp_valid_in             = 1'b1;
            rsp_data_in.frame_type   = job_data.frame_type;
            rsp_data_in.status       = status;
            rsp_data_in.word0        = job_data.word0;
            rsp_data_in.word1        = job_data.word1;
            rsp_data_in.word2        = job_data.word2;
            rsp_data_in.word3        = job_data.word3;
            rsp_data_in.angle_seen   = angle_flag_in;
            rsp_data_in.quat_seen    = quat_flag_in;
            rsp_data_in.angle_frames = isfp_pkg::OUT_CNT_BITS'(angle_cnt_in);
            rsp_data_in.quat_frames  = isfp_pkg::OUT_CNT_BITS'(quat_cnt_in);
            rsp_data_in.bad_sums     = isfp_pkg::OUT_CNT_BITS'(fail_cnt_in);
            rsp_data_in.bytes_seen   = job_data.byte_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_flag_ff <= 1'b0;
         quat_flag_ff  <= 1'b0;
         angle_cnt_ff  <= '0;
         quat_cnt_ff   <= '0;
         fail_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         angle_flag_ff <= angle_flag_in;
         quat_flag_ff  <= quat_flag_in;
         angle_cnt_ff  <= angle_cnt_in;
         quat_cnt_ff   <= quat_cnt_in;
         fail_cnt_ff   <= fail_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/imu_serial_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_serial_frame_parser: 11-byte sensor frame parser
// Parses received serial bytes into frames and reports each finished frame.
// ----------------------------------------------------------------------------
// One transfer on req_ carries either a received byte (cmd low) or a resync
// command (cmd high). The parser takes one transfer every clock cycle: it
// hunts for header 0x55, skips repeated headers, collects the type byte and
// eight payload bytes with a running 8-bit sum, and checks the sum against
// the eleventh byte. Each finished frame gives one rsp_ transfer with the
// type, a status (angle, quaternion, other type, checksum failure), four
// little-endian signed words, the valid flags and the wrapping counters.
// Resync restarts the hunt and clears both flags; counters are kept. The
// front parser and the back classifier are joined by a QUEUE_DEPTH-entry
// job queue, so req_ready stays high at one transfer per cycle until
// QUEUE_DEPTH jobs (frames or resyncs) wait behind a stalled rsp_ side;
// a frame's report passes through a queue slot and the output register.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser #(
   parameter int COUNTER_BITS = 32,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  isfp_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output isfp_pkg::rsp_payload_type rsp_data
);

   logic              req_fire;
   logic              push_valid;
   isfp_pkg::job_type push_data;
   logic              q_full;
   logic              q_valid;
   logic              q_pop;
   isfp_pkg::job_type q_data;

   // a free queue slot covers any job this transfer may raise
   assign req_ready = !q_full;
   assign req_fire  = req_valid && req_ready;

   // front: header hunt, payload capture, running checksum, byte counter
   isfp_front #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // jobs in order: frames and flag clears
   isfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   // back: status, flags, frame counters, output register
   isfp_back #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_data  (q_data),
      .job_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* bench/isfp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfp_checker: frame report checker for the sensor frame parser
// Follows every req_ transfer with its own copy of the frame parser, queues
// the report each checksum byte should give and compares every rsp_
// transfer with the oldest queued report, field by field.
// ----------------------------------------------------------------------------
module isfp_checker
   import isfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_data,
   output int              mismatches,
   output int              reports_due,
   output int              reports_seen,
   output int              bad_sum_reports,
   output int              input_stalls
);

   localparam int STORE_LEN = PAYLOAD_LEN + 1;
   localparam int MAX_SHOWN = 10;

   typedef enum logic [1:0] {
      SEEK_HEADER,
      SEEK_TYPE,
      SEEK_PAYLOAD,
      SEEK_SPARE
   } seek_type;

   seek_type    seek;
   logic [7:0]  frame_kind;
   logic [3:0]  slot;
   logic [7:0]  store [STORE_LEN];
   logic        angle_flag;
   logic        quat_flag;
   logic [31:0] angle_cnt;
   logic [31:0] quat_cnt;
   logic [31:0] bad_cnt;
   logic [31:0] byte_cnt;

   rsp_payload_type frames_due[$];
   int miss_cnt;
   int seen_cnt;
   int bad_seen;
   int stall_cnt;

   // parser state update for one accepted transfer
   function automatic void parse_transfer(input req_payload_type item);
      rsp_payload_type rep;
      logic [7:0]      sum;
      logic [1:0]      st;
      if (item.cmd) begin
         seek       = SEEK_HEADER;
         frame_kind = '0;
         slot       = '0;
         angle_flag = 1'b0;
         quat_flag  = 1'b0;
         return;
      end
      byte_cnt = byte_cnt + 1;
      case (seek)
         SEEK_HEADER: begin
            if (item.rx_byte == HEADER_BYTE) seek = SEEK_TYPE;
         end
         SEEK_TYPE: begin
            // repeated headers are skipped here
            if (item.rx_byte != HEADER_BYTE) begin
               frame_kind = item.rx_byte;
               slot       = '0;
               seek       = SEEK_PAYLOAD;
            end
         end
         SEEK_PAYLOAD: begin
            if (slot >= STORE_LEN) slot = 4'(STORE_LEN - 1);
            store[slot] = item.rx_byte;
            slot = slot + 4'd1;
            if (slot >= STORE_LEN) begin
               seek = SEEK_HEADER;
               sum  = HEADER_BYTE + frame_kind;
               for (int k = 0; k < PAYLOAD_LEN; k++) sum = sum + store[k];
               if (sum != store[PAYLOAD_LEN]) begin
                  bad_cnt = bad_cnt + 1;
                  st      = STATUS_BAD;
               end else if (frame_kind == TYPE_ANGLE) begin
                  angle_flag = 1'b1;
                  angle_cnt  = angle_cnt + 1;
                  st         = STATUS_ANGLE;
               end else if (frame_kind == TYPE_QUAT) begin
                  quat_flag = 1'b1;
                  quat_cnt  = quat_cnt + 1;
                  st        = STATUS_QUAT;
               end else begin
                  st = STATUS_OTHER;
               end
               rep.frame_type   = frame_kind;
               rep.status       = st;
               rep.word0        = {store[1], store[0]};
               rep.word1        = {store[3], store[2]};
               rep.word2        = {store[5], store[4]};
               rep.word3        = {store[7], store[6]};
               rep.angle_seen   = angle_flag;
               rep.quat_seen    = quat_flag;
               rep.angle_frames = angle_cnt;
               rep.quat_frames  = quat_cnt;
               rep.bad_sums     = bad_cnt;
               rep.bytes_seen   = byte_cnt;
               frames_due.push_back(rep);
            end
         end
         default: seek = SEEK_HEADER;
      endcase
   endfunction

   function automatic bit field_off(input string name, input logic [31:0] want,
                                    input logic [31:0] got, input bit loud);
      if (want === got) return 1'b0;
      if (loud) $display("   %s: expected %0h, got %0h", name, want, got);
      return 1'b1;
   endfunction

   function automatic void check_report(input rsp_payload_type got);
      rsp_payload_type want;
      bit              loud;
      bit              off;
      loud = (miss_cnt < MAX_SHOWN);
      seen_cnt++;
      if (got.status == STATUS_BAD) bad_seen++;
      if (frames_due.size() == 0) begin
         if (loud) $display("%0t: frame report with none due, type %0h status %0d",
                            $time, got.frame_type, got.status);
         miss_cnt++;
         return;
      end
      want = frames_due.pop_front();
      if (loud && want !== got) $display("%0t: frame report %0d differs", $time, seen_cnt);
      off = field_off("frame_type", want.frame_type, got.frame_type, loud)
          | field_off("status", want.status, got.status, loud)
          | field_off("word0", want.word0, got.word0, loud)
          | field_off("word1", want.word1, got.word1, loud)
          | field_off("word2", want.word2, got.word2, loud)
          | field_off("word3", want.word3, got.word3, loud)
          | field_off("angle_seen", want.angle_seen, got.angle_seen, loud)
          | field_off("quat_seen", want.quat_seen, got.quat_seen, loud)
          | field_off("angle_frames", want.angle_frames, got.angle_frames, loud)
          | field_off("quat_frames", want.quat_frames, got.quat_frames, loud)
          | field_off("bad_sums", want.bad_sums, got.bad_sums, loud)
          | field_off("bytes_seen", want.bytes_seen, got.bytes_seen, loud);
      if (off) miss_cnt++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         seek       = SEEK_HEADER;
         frame_kind = '0;
         slot       = '0;
         angle_flag = 1'b0;
         quat_flag  = 1'b0;
         angle_cnt  = '0;
         quat_cnt   = '0;
         bad_cnt    = '0;
         byte_cnt   = '0;
         frames_due.delete();
         miss_cnt   = 0;
         seen_cnt   = 0;
         bad_seen   = 0;
         stall_cnt  = 0;
      end else begin
         if (req_valid && req_ready) parse_transfer(req_data);
         if (req_valid && !req_ready) stall_cnt++;
         if (rsp_valid && rsp_ready) check_report(rsp_data);
      end
      mismatches      <= miss_cnt;
      reports_due     <= frames_due.size();
      reports_seen    <= seen_cnt;
      bad_sum_reports <= bad_seen;
      input_stalls    <= stall_cnt;
   end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the sensor frame parser
// Feeds byte streams and resync commands: a short directed run, then random
// streams of mostly well-formed frames mixed with noise, repeated headers,
// cut frames and bad checksums, under three idling profiles and a long
// receiver hold-off. The checker beside the block gives the mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
   import isfp_pkg::*;

   localparam logic CMD_BYTE   = 1'b0;
   localparam logic CMD_RESYNC = 1'b1;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 295;
   localparam int TAIL_CYCLES = 20;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;

   int mismatches;
   int reports_due;
   int reports_seen;
   int bad_sum_reports;
   int input_stalls;

   // stimulus bookkeeping
   int items_sent;
   int resyncs_sent;
   int req_idle_pct;
   int rsp_idle_pct;
   int cycle_count;
   int hold_left;
   bit hold_req;

   imu_serial_frame_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   isfp_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .mismatches      (mismatches),
      .reports_due     (reports_due),
      .reports_seen    (reports_seen),
      .bad_sum_reports (bad_sum_reports),
      .input_stalls    (input_stalls)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog on total run length
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports still due", cycle_count, reports_due);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random ready per cycle, or a long hold-off when asked;
   // the hold is counted here so the sender keeps offering meanwhile
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            for (hold_left = HOLD_CYCLES - 1; hold_left > 0; hold_left--) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // one req_ transfer: optional idle gap, then hold valid until accepted
   task automatic send_item(input logic cmd, input logic [7:0] value);
      req_payload_type item;
      item.cmd     = cmd;
      item.rx_byte = value;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (cmd == CMD_RESYNC) resyncs_sent++;
   endtask

   // header, repeated headers, type, then the first 'keep' of the nine
   // payload and checksum bytes; an optional resync ends a cut frame
   task automatic send_frame(input logic [7:0] kind, input int extra_heads,
                             input bit extremes, input bit corrupt,
                             input int keep, input bit resync_after);
      logic [7:0] body [PAYLOAD_LEN + 1];
      logic [7:0] sum;
      sum = HEADER_BYTE + kind;
      for (int k = 0; k < PAYLOAD_LEN; k++) begin
         if (extremes) begin
            case ($urandom_range(3))
               0: body[k] = 8'h00;
               1: body[k] = 8'h7F;
               2: body[k] = 8'h80;
               default: body[k] = 8'hFF;
            endcase
         end else begin
            body[k] = 8'($urandom_range(255));
         end
         sum = sum + body[k];
      end
      if (corrupt) sum = sum + 8'($urandom_range(1, 255));
      body[PAYLOAD_LEN] = sum;
      send_item(CMD_BYTE, HEADER_BYTE);
      repeat (extra_heads) send_item(CMD_BYTE, HEADER_BYTE);
      send_item(CMD_BYTE, kind);
      for (int k = 0; k < keep; k++) send_item(CMD_BYTE, body[k]);
      if (resync_after) send_item(CMD_RESYNC, 8'($urandom_range(255)));
   endtask

   // sender pause until every due report has been taken
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (reports_due != 0) @(negedge clock);
   endtask

   // random stream: mostly whole frames, plus noise and broken frames
   task automatic run_stream(input int req_pct, input int rsp_pct, input int quota);
      int         stop_at;
      int         pick;
      logic [7:0] kind;
      stop_at      = items_sent + quota;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         case ($urandom_range(9))
            0, 1, 2, 3: kind = TYPE_ANGLE;
            4, 5, 6:    kind = TYPE_QUAT;
            default:    kind = 8'($urandom_range(255));
         endcase
         if (pick < 70) begin
            send_frame(kind, ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0,
                       ($urandom_range(3) == 0), ($urandom_range(6) == 0),
                       PAYLOAD_LEN + 1, 1'b0);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 5)) send_item(CMD_BYTE, 8'($urandom_range(255)));
         end else if (pick < 88) begin
            // frame cut short by a resync
            send_frame(kind, 0, 1'b0, 1'b0, $urandom_range(PAYLOAD_LEN), 1'b1);
         end else if (pick < 93) begin
            send_item(CMD_RESYNC, 8'($urandom_range(255)));
         end else begin
            // cut frame; the next header lands in its payload
            send_frame(kind, 0, 1'b0, 1'b0, $urandom_range(PAYLOAD_LEN), 1'b0);
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      items_sent   = 0;
      resyncs_sent = 0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_req     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: noise while hunting, repeated header before an angle
      // frame of extreme bytes, a quaternion frame cut by a resync
      send_item(CMD_BYTE, 8'hFF);
      send_frame(TYPE_ANGLE, 1, 1'b1, 1'b0, PAYLOAD_LEN + 1, 1'b0);
      send_frame(TYPE_QUAT, 0, 1'b1, 1'b0, 2, 1'b0);
      send_item(CMD_RESYNC, 8'hFF);
      send_item(CMD_BYTE, 8'h00);
      wait_drained();

      // receiver-heavy idling, then sender-heavy idling
      run_stream(31, 56, PHASE_ITEMS);
      wait_drained();
      run_stream(56, 31, PHASE_ITEMS);
      wait_drained();

      // no idling; a long receiver hold-off at the start fills the block
      hold_req = 1'b1;
      run_stream(0, 0, PHASE_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d transfers (%0d resync commands) and %0d frame reports",
               items_sent, resyncs_sent, reports_seen);
      $display("%0d reports with bad checksum, input held off %0d cycles by back-pressure",
               bad_sum_reports, input_stalls);
      if (mismatches == 0 && reports_due == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d reports never arrived", mismatches, reports_due);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
